// File: design/atilt_pkg.sv
// Shared constants, control types and constant functions for the accelerometer tilt pipeline.
package atilt_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  // Radian accumulator format and arctangent pipeline length
  localparam int ACC_Q        = 61;
  localparam int CORDIC_STEPS = 62;
  localparam logic [63:0] PI_Q61         = 64'h6487ED5110B4611A;
  localparam logic [63:0] QUARTER_PI_Q61 = 64'h1921FB54442D1847;

  // Square root unit: normalize, root digits, remainder quotient, output
  localparam int NORM_STEPS = 5;
  localparam int ROOT_STEPS = 32;
  localparam int QUO_BITS   = 17;
  localparam int SQRT_LAT   = NORM_STEPS + ROOT_STEPS + QUO_BITS + 1;
  localparam int ROOT_W     = 49;
  localparam int SHIFT_W    = 6;

  typedef struct packed {
    logic vld;
    logic v_zero;
    logic u_zero;
    logic flip;
    logic neg;
  } lane_ctl_t;

  function automatic int lane_latency(input int frac);
    return 8 + CORDIC_STEPS + 1 + (frac + 8) + 1;
  endfunction

  function automatic int top_latency(input int frac);
    return 2 + SQRT_LAT + 1 + lane_latency(frac);
  endfunction

  // atan(2^-i) in Q61 from the power series, evaluated at elaboration
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    int k;
    sum = '0;
    if (i == 0) begin
      return QUARTER_PI_Q61;
    end
    for (k = 0; k <= ACC_Q; k++) begin
      e = i * (2 * k + 1);
      if (e <= ACC_Q) begin
        term = (64'd1 << (ACC_Q - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

endpackage

// File: design/atilt_sqrt.sv
// Pipelined square root of the sum of squares with a 17-bit remainder quotient.
module atilt_sqrt import atilt_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [63:0]         s,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [ROOT_W-1:0]   root,
  output logic [SHIFT_W-1:0]  shift,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int T_N = NORM_STEPS;
  localparam int T_R = T_N + ROOT_STEPS;
  localparam int T_D = T_R + QUO_BITS;
  localparam int LAT = T_D + 1;

  logic              vld_s  [0:LAT-1];
  logic [SIDE_W-1:0] side_s [0:LAT-1];
  logic              zero_s [0:T_D];
  logic [4:0]        half_s [0:T_D];
  logic [63:0]       n_s    [0:T_R];
  logic [63:0]       res_s  [T_N:T_R];
  logic [49:0]       rem_s  [T_R:T_D-1];
  logic [16:0]       q_s    [T_R:T_D];
  logic [31:0]       root_s [T_R:T_D];

  assign vld_s[0]   = in_vld;
  assign side_s[0]  = in_side;
  assign zero_s[0]  = (s == '0);
  assign half_s[0]  = '0;
  assign n_s[0]     = s;
  assign res_s[T_N] = '0;
  assign rem_s[T_R] = {n_s[T_R][33:0], 16'b0};
  assign q_s[T_R]   = '0;
  assign root_s[T_R] = res_s[T_R][31:0];

  for (genvar t = 1; t < LAT; t++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[t] <= 1'b0;
      end else begin
        vld_s[t] <= vld_s[t-1];
      end
      side_s[t] <= side_s[t-1];
    end
  end

  for (genvar t = 1; t <= T_D; t++) begin : g_zero
    always_ff @(posedge clk) begin
      zero_s[t] <= zero_s[t-1];
    end
  end

  // Normalize: shift left by pairs of bits until one of the top two bits is set
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int K = 16 >> j;
    always_ff @(posedge clk) begin
      if (n_s[j][63 -: 2*K] == '0) begin
        n_s[j+1]    <= n_s[j] << (2 * K);
        half_s[j+1] <= half_s[j] + 5'(K);
      end else begin
        n_s[j+1]    <= n_s[j];
        half_s[j+1] <= half_s[j];
      end
    end
  end

  for (genvar t = T_N + 1; t <= T_D; t++) begin : g_half
    always_ff @(posedge clk) begin
      half_s[t] <= half_s[t-1];
    end
  end

  // One root digit per stage
  for (genvar r = 0; r < ROOT_STEPS; r++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * r);
    logic [64:0] trial;
    assign trial = {1'b0, res_s[T_N+r]} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if ({1'b0, n_s[T_N+r]} >= trial) begin
        n_s[T_N+r+1]   <= n_s[T_N+r] - trial[63:0];
        res_s[T_N+r+1] <= (res_s[T_N+r] >> 1) + BIT;
      end else begin
        n_s[T_N+r+1]   <= n_s[T_N+r];
        res_s[T_N+r+1] <= res_s[T_N+r] >> 1;
      end
    end
  end

  // Remainder over twice the root, one quotient bit per stage
  for (genvar d = 0; d < QUO_BITS; d++) begin : g_quo
    localparam int B = QUO_BITS - 1 - d;
    logic [49:0] dv;
    logic        ge;
    assign dv = 50'({root_s[T_R+d], 1'b0}) << B;
    assign ge = (rem_s[T_R+d] >= dv);
    always_ff @(posedge clk) begin
      q_s[T_R+d+1]    <= {q_s[T_R+d][15:0], ge};
      root_s[T_R+d+1] <= root_s[T_R+d];
    end
    if (d < QUO_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_s[T_R+d+1] <= ge ? rem_s[T_R+d] - dv : rem_s[T_R+d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_s[LAT-1];
    end
    out_side <= side_s[LAT-1];
    if (zero_s[T_D]) begin
      root  <= '0;
      shift <= '0;
    end else begin
      root  <= ROOT_W'({root_s[T_D], 16'b0}) + ROOT_W'(q_s[T_D]);
      shift <= SHIFT_W'(half_s[T_D]) + SHIFT_W'(16);
    end
  end

endmodule

// File: design/atilt_lane.sv
// One arctangent lane: normalize, vectoring CORDIC, scale to degrees, sign fix-up.
module atilt_lane import atilt_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int OUT_W           = ANGLE_FRAC_BITS_DEF + 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic [63:0]             u,
  input  logic [63:0]             v,
  input  logic                    flip_req,
  input  logic                    neg_req,
  output logic                    out_vld,
  output logic signed [OUT_W-1:0] angle
);

  localparam int QW       = ANGLE_FRAC_BITS + 8;
  localparam int SCALE_SH = ACC_Q - (54 - ANGLE_FRAC_BITS);
  localparam int ZQ_W     = 62 - SCALE_SH;
  localparam int T_CORD   = 8;
  localparam int T_POST   = T_CORD + CORDIC_STEPS + 1;
  localparam int T_FIN    = T_POST + QW + 1;
  localparam logic [63:0] P_DIV =
    (PI_Q61 + (64'd1 << (SCALE_SH - 1))) >> SCALE_SH;
  localparam logic [63:0] HALF_P    = P_DIV >> 1;
  localparam logic [63:0] HALF_TURN = 64'd180 << ANGLE_FRAC_BITS;
  localparam logic [QW-1:0] NINETY_Q    = QW'(90 << ANGLE_FRAC_BITS);
  localparam logic [QW-1:0] HALF_TURN_Q = QW'(180 << ANGLE_FRAC_BITS);

  lane_ctl_t          ctl_s [1:T_FIN-1];
  logic [63:0]        u_s   [1:T_CORD];
  logic [63:0]        v_s   [1:T_CORD];
  logic [63:0]        mx_s  [1:T_CORD-1];
  logic signed [63:0] x_s   [T_CORD:T_POST-1];
  logic signed [63:0] y_s   [T_CORD:T_POST-1];
  logic signed [63:0] z_s   [T_CORD:T_POST-1];
  logic [63:0]        rem_s [T_POST:T_POST+QW-1];
  logic [QW-1:0]      q_s   [T_POST:T_POST+QW];

  assign x_s[T_CORD] = $signed(u_s[T_CORD]);
  assign y_s[T_CORD] = $signed(v_s[T_CORD]);
  assign z_s[T_CORD] = '0;
  assign q_s[T_POST] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[1] <= '0;
    end else begin
      ctl_s[1].vld    <= in_vld;
      ctl_s[1].v_zero <= (v == '0);
      ctl_s[1].u_zero <= (u == '0);
      ctl_s[1].flip   <= flip_req && (u != '0);
      ctl_s[1].neg    <= neg_req && (v != '0);
    end
    u_s[1]  <= u;
    v_s[1]  <= v;
    mx_s[1] <= (u > v) ? u : v;
  end

  for (genvar t = 2; t < T_FIN; t++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[t] <= '0;
      end else begin
        ctl_s[t] <= ctl_s[t-1];
      end
    end
  end

  // Bring the larger operand below 2^60
  logic [2:0] rsh;
  always_comb begin
    if (mx_s[1][63]) begin
      rsh = 3'd4;
    end else if (mx_s[1][62]) begin
      rsh = 3'd3;
    end else if (mx_s[1][61]) begin
      rsh = 3'd2;
    end else if (mx_s[1][60]) begin
      rsh = 3'd1;
    end else begin
      rsh = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    u_s[2]  <= u_s[1] >> rsh;
    v_s[2]  <= v_s[1] >> rsh;
    mx_s[2] <= mx_s[1] >> rsh;
  end

  // Raise the larger operand to at least 2^59
  for (genvar t = 3; t <= T_CORD; t++) begin : g_lsh
    localparam int K = 32 >> (t - 3);
    logic up;
    assign up = (mx_s[t-1][59 -: K] == '0);
    always_ff @(posedge clk) begin
      u_s[t] <= up ? (u_s[t-1] << K) : u_s[t-1];
      v_s[t] <= up ? (v_s[t-1] << K) : v_s[t-1];
    end
    if (t < T_CORD) begin : g_mx
      always_ff @(posedge clk) begin
        mx_s[t] <= up ? (mx_s[t-1] << K) : mx_s[t-1];
      end
    end
  end

  // Vectoring iterations: drive y toward zero, accumulate the angle
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic [63:0] ANG = atan_entry(i);
    always_ff @(posedge clk) begin
      if (!y_s[T_CORD+i][63]) begin
        x_s[T_CORD+i+1] <= x_s[T_CORD+i] + (y_s[T_CORD+i] >>> i);
        y_s[T_CORD+i+1] <= y_s[T_CORD+i] - (x_s[T_CORD+i] >>> i);
        z_s[T_CORD+i+1] <= z_s[T_CORD+i] + $signed(ANG);
      end else begin
        x_s[T_CORD+i+1] <= x_s[T_CORD+i] - (y_s[T_CORD+i] >>> i);
        y_s[T_CORD+i+1] <= y_s[T_CORD+i] + (x_s[T_CORD+i] >>> i);
        z_s[T_CORD+i+1] <= z_s[T_CORD+i] - $signed(ANG);
      end
    end
  end

  // Clamp, drop to output precision, scale by half a turn and add half the divisor
  logic [ZQ_W-1:0] zq;
  assign zq = z_s[T_POST-1][63] ? '0 : z_s[T_POST-1][61:SCALE_SH];

  always_ff @(posedge clk) begin
    rem_s[T_POST] <= 64'(zq) * HALF_TURN + HALF_P;
  end

  // Divide by pi at output scale, one quotient bit per stage
  for (genvar d = 0; d < QW; d++) begin : g_div
    localparam logic [63:0] DV = P_DIV << (QW - 1 - d);
    logic ge;
    assign ge = (rem_s[T_POST+d] >= DV);
    always_ff @(posedge clk) begin
      q_s[T_POST+d+1] <= {q_s[T_POST+d][QW-2:0], ge};
    end
    if (d < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_s[T_POST+d+1] <= ge ? rem_s[T_POST+d] - DV : rem_s[T_POST+d];
      end
    end
  end

  logic [QW-1:0]      mag;
  logic [QW-1:0]      mag_f;
  logic signed [QW:0] sval;
  always_comb begin
    if (ctl_s[T_FIN-1].v_zero) begin
      mag = '0;
    end else if (ctl_s[T_FIN-1].u_zero) begin
      mag = NINETY_Q;
    end else begin
      mag = q_s[T_POST+QW];
    end
    mag_f = ctl_s[T_FIN-1].flip ? HALF_TURN_Q - mag : mag;
    sval  = ctl_s[T_FIN-1].neg ? -$signed({1'b0, mag_f}) : $signed({1'b0, mag_f});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= ctl_s[T_FIN-1].vld;
    end
    angle <= sval[OUT_W-1:0];
  end

endmodule

// File: design/accel_tilt_angles_top.sv
// Top level of the accelerometer tilt-angle pipeline (third angle, pitch, roll).
// Throughput: one transaction per cycle while busy is low; every stage is a flop stage, nothing iterates.
// The receiver cannot stall: done and the angles are shown for exactly one cycle.
// Reset is synchronous: it clears every valid bit, and busy is high for the cycle after reset.
module accel_tilt_angles_top import atilt_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_BITS-1:0]       accel_x,
  input  logic signed [SAMPLE_BITS-1:0]       accel_y,
  input  logic signed [SAMPLE_BITS-1:0]       accel_z,
  output logic                                done,
  output logic signed [ANGLE_FRAC_BITS+7:0]   third_angle,
  output logic signed [ANGLE_FRAC_BITS+7:0]   pitch_deg,
  output logic signed [ANGLE_FRAC_BITS+8:0]   roll_deg
);

  localparam int MW     = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SIDE_W = 3 + 3 * MW;
  localparam int ANG_W  = ANGLE_FRAC_BITS + 8;
  localparam int ROLL_W = ANGLE_FRAC_BITS + 9;

  // The pipeline never backs up, so busy only covers the cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Stage 1: capture magnitudes and signs. The most negative sample maps to
  // 2^(SAMPLE_BITS-1), which the unsigned magnitude holds exactly.
  logic          v1;
  logic [MW-1:0] ax1, ay1, az1;
  logic          xpos1, yneg1, zneg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    ax1   <= accel_x[SAMPLE_BITS-1] ? (~accel_x + 1'b1) : accel_x;
    ay1   <= accel_y[SAMPLE_BITS-1] ? (~accel_y + 1'b1) : accel_y;
    az1   <= accel_z[SAMPLE_BITS-1] ? (~accel_z + 1'b1) : accel_z;
    xpos1 <= !accel_x[SAMPLE_BITS-1] && (accel_x != '0);
    yneg1 <= accel_y[SAMPLE_BITS-1];
    zneg1 <= accel_z[SAMPLE_BITS-1];
  end

  // Stage 2: exact sum of squares x^2 + z^2.
  logic [SQ_W-1:0]   sqx, sqz;
  logic              v2;
  logic [SQ_W-1:0]   s2;
  logic [SIDE_W-1:0] side2;

  assign sqx = ax1 * ax1;
  assign sqz = az1 * az1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2    <= sqx + sqz;
    side2 <= {xpos1, yneg1, zneg1, ax1, ay1, az1};
  end

  // Square root with extra fraction bits; roll operands ride along as sideband.
  logic               sq_vld;
  logic [ROOT_W-1:0]  sq_root;
  logic [SHIFT_W-1:0] sq_shift;
  logic [SIDE_W-1:0]  sq_side;
  logic               sq_xpos, sq_yneg, sq_zneg;
  logic [MW-1:0]      sq_ax, sq_ay, sq_az;

  atilt_sqrt #(
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v2),
    .s        (64'(s2)),
    .in_side  (side2),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .shift    (sq_shift),
    .out_side (sq_side)
  );

  assign {sq_xpos, sq_yneg, sq_zneg, sq_ax, sq_ay, sq_az} = sq_side;

  // Stage 3: scale |z| and |y| to the root's fixed point; hold roll operands.
  logic          v3;
  logic [63:0]   hyp3, zsc3, ysc3;
  logic [MW-1:0] ax3, az3;
  logic          xpos3, yneg3, zneg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= sq_vld;
    end
    hyp3  <= 64'(sq_root);
    zsc3  <= 64'(sq_az) << sq_shift;
    ysc3  <= 64'(sq_ay) << sq_shift;
    ax3   <= sq_ax;
    az3   <= sq_az;
    xpos3 <= sq_xpos;
    yneg3 <= sq_yneg;
    zneg3 <= sq_zneg;
  end

  // Three arctangent lanes run in lockstep; the roll lane has a wider output.
  logic vld_third, vld_pitch, vld_roll;

  atilt_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .OUT_W           (ANG_W)
  ) u_lane_third (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v3),
    .u        (hyp3),
    .v        (zsc3),
    .flip_req (1'b0),
    .neg_req  (zneg3),
    .out_vld  (vld_third),
    .angle    (third_angle)
  );

  atilt_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .OUT_W           (ANG_W)
  ) u_lane_pitch (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v3),
    .u        (hyp3),
    .v        (ysc3),
    .flip_req (1'b0),
    .neg_req  (yneg3),
    .out_vld  (vld_pitch),
    .angle    (pitch_deg)
  );

  // Roll = atan2(-x, z): reflect through 180 degrees when z is negative.
  atilt_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .OUT_W           (ROLL_W)
  ) u_lane_roll (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v3),
    .u        (64'(az3)),
    .v        (64'(ax3)),
    .flip_req (zneg3),
    .neg_req  (xpos3),
    .out_vld  (vld_roll),
    .angle    (roll_deg)
  );

  assign done = vld_third && vld_pitch && vld_roll;

endmodule

// File: design/atilt_check.sv
// Port-level assertions for the tilt-angle pipeline and their bind to the top level.
module atilt_check import atilt_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic signed [SAMPLE_BITS-1:0]     accel_x,
  input logic signed [SAMPLE_BITS-1:0]     accel_y,
  input logic signed [SAMPLE_BITS-1:0]     accel_z,
  input logic                              done,
  input logic signed [ANGLE_FRAC_BITS+7:0] third_angle,
  input logic signed [ANGLE_FRAC_BITS+7:0] pitch_deg,
  input logic signed [ANGLE_FRAC_BITS+8:0] roll_deg
);

  localparam int LAT       = top_latency(ANGLE_FRAC_BITS);
  localparam int NINETY    = 90 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;

  a_known_samples: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown({accel_x, accel_y, accel_z}))
    else $error("accepted transaction carries unknown sample bits");

  a_every_txn_completes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted transaction produced no result after fixed latency");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching accepted transaction");

  a_half_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(third_angle) <= NINETY && $signed(third_angle) >= -NINETY &&
              $signed(pitch_deg) <= NINETY && $signed(pitch_deg) >= -NINETY))
    else $error("third angle or pitch outside +/-90 degrees");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(roll_deg) <= HALF_TURN && $signed(roll_deg) >= -HALF_TURN))
    else $error("roll outside +/-180 degrees");

endmodule

bind accel_tilt_angles_top atilt_check #(
  .SAMPLE_BITS     (SAMPLE_BITS),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atilt_check (.*);
